### sv/mcs_pkg.sv
package mcs_pkg;

	localparam int CHORD_NOTES_DEF = 8;
	localparam int NOTE_TYPES = 14;
	localparam int QT_W = 16;
	localparam int CNT_W = 21;

	localparam logic [15:0] QUARTER_RST = 16'd500;
	localparam logic [7:0] STATUS_ON = 8'h90;
	localparam logic [7:0] STATUS_OFF = 8'h80;
	localparam logic [7:0] OFF_VELOCITY = 8'd64;
	localparam logic [7:0] LEVEL_MAX = 8'd127;
	localparam logic [7:0] SUS_RST = 8'd100;
	localparam logic [7:0] PAU_RST = 8'd20;
	localparam logic [7:0] LVL_RST = 8'd70;

	typedef enum logic [2:0] {
		ACT_TICK = 3'd0, ACT_ADD = 3'd1, ACT_SET = 3'd2, ACT_DELTA = 3'd3,
		ACT_MODE = 3'd4, ACT_STOP = 3'd5, ACT_RESUME = 3'd6, ACT_TYPE = 3'd7
	} action_t;

	typedef enum logic [0:0] {
		REG_QUARTER = 1'b0, REG_CHANNEL = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0, MODE_SEQ = 2'd1, MODE_DELTA = 2'd2, MODE_OTHER = 2'd3
	} op_mode_t;

	typedef enum logic [3:0] {
		SQ_INIT, SQ_IDLE, SQ_ON, SQ_SUS, SQ_OFF, SQ_PAUSE, SQ_WAIT, SQ_REL, SQ_NEW
	} seq_t;

	typedef enum logic [3:0] {
		CT_IDLE, CT_DISPATCH, CT_ON_HDR, CT_ON_VAL, CT_ON_MUL1, CT_ON_MUL2,
		CT_ON_MUL3, CT_ON_LVL, CT_SUS, CT_OFF_HDR, CT_OFF_VAL, CT_OFF_VEL,
		CT_EMIT, CT_ADD
	} ctl_t;

	// type length from quarter length (shifts and adds only)
	function automatic logic [CNT_W-1:0] type_length(input logic [3:0] t,
		input logic [QT_W-1:0] q);
		logic [CNT_W-1:0] qq;
		begin
			qq = CNT_W'(q);
			case (t)
				4'd0: type_length = qq << 3;
				4'd1: type_length = qq << 2;
				4'd2: type_length = (qq << 1) + qq;
				4'd3: type_length = qq << 1;
				4'd4: type_length = qq + (qq >> 1);
				4'd5: type_length = qq;
				4'd6: type_length = qq >> 1;
				4'd7: type_length = (qq >> 1) + (qq >> 2);
				4'd8: type_length = qq >> 2;
				4'd9: type_length = (qq >> 2) + (qq >> 3);
				4'd10: type_length = qq >> 3;
				4'd11: type_length = (qq >> 3) + (qq >> 4);
				4'd12: type_length = qq >> 4;
				4'd13: type_length = (qq >> 4) + (qq >> 5);
				default: type_length = '0;
			endcase
		end
	endfunction

endpackage

### sv/mcs_if.sv
interface mcs_in_if;
	import mcs_pkg::*;
	logic valid;
	logic ready;
	logic [2:0] action;
	logic [3:0] slot;
	logic [3:0] type_index;
	logic [7:0] note_value;
	logic [7:0] velocity;
	logic [1:0] mode;
	logic [7:0] sustain_pct;
	logic [7:0] pause_pct;
	logic [7:0] level_pct;
	modport source (output valid, action, slot, type_index, note_value, velocity, mode,
		sustain_pct, pause_pct, level_pct, input ready);
	modport sink (input valid, action, slot, type_index, note_value, velocity, mode,
		sustain_pct, pause_pct, level_pct, output ready);
endinterface

interface mcs_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] data_byte;
	logic [4:0] slot_taken;
	logic last;
	modport source (output valid, kind, data_byte, slot_taken, last, input ready);
	modport sink (input valid, kind, data_byte, slot_taken, last, output ready);
endinterface

interface mcs_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/mcs_divmul.sv
// Shared multiply-by-constant-reciprocal unit: q = (a*b)/100, computed in a pipeline.
module mcs_divmul import mcs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] a,
	input  logic [7:0]       b,
	output logic             done,
	output logic [CNT_W-1:0] q
);
	logic [28:0] prod_s1;
	logic [57:0] rec_s2;
	logic [28:0] prod_s2;
	logic [28:0] est;
	logic [28:0] rem;
	logic [2:0]  vld_q;

	// divide by 100: multiply by ceil(2^35/100); exact for values below 2^29 after fixup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], start};
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 29'(a) * 29'(b);
		rec_s2  <= 58'(prod_s1) * 58'd343597384;
		prod_s2 <= prod_s1;
	end

	always_comb begin
		est = 29'(rec_s2 >> 35);
		rem = prod_s2 - 29'(est * 29'd100);
	end

	// register the quotient so it lines up with done
	always_ff @(posedge clk) begin
		if (rem >= 29'd100) q <= CNT_W'(est + 29'd1);
		else q <= CNT_W'(est);
	end
	assign done = vld_q[2];
endmodule

### sv/midi_chord_sequencer.sv
// Channel  Dir  Contents
// in       in   action slot type_index note_value velocity mode pcts
// out      out  kind data_byte slot_taken last
// cfg      in   index data (0 quarter_ticks, 1 channel)
// An item is accepted, then dispatched, then worked: a note-on tick runs each chord note
// through the shared multiply/divide-by-100 unit, a sustain tick walks the used chord
// entries one per cycle, and other result bytes go out one per cycle while out.ready holds.
// arst_n clears control state, chord used bits, pending and delta flags; type table to defaults.
// Output stalls hold the sequencer; in.ready is high only while no item is in work.
module midi_chord_sequencer import mcs_pkg::*; #(
	parameter int CHORD_NOTES = CHORD_NOTES_DEF
) (
	input logic clk,
	input logic arst_n,
	mcs_in_if.sink   in,
	mcs_out_if.source out,
	mcs_cfg_if.sink  cfg
);
	localparam int IW = (CHORD_NOTES > 1) ? $clog2(CHORD_NOTES) : 1;
	localparam int SW = $clog2(CHORD_NOTES + 1);

	// configuration
	logic [QT_W-1:0] quarter_q;
	logic [3:0]      channel_q;

	// sequencer state
	seq_t     seq_q;
	op_mode_t mode_q;
	logic     stop_req_q, stopped_q;
	logic [CHORD_NOTES-1:0] used_q, pend_q, dnew_q;
	logic [3:0] ch_type_q [CHORD_NOTES];
	logic [7:0] ch_val_q  [CHORD_NOTES];
	logic [7:0] ch_vel_q  [CHORD_NOTES];
	logic [3:0] pd_type_q [CHORD_NOTES];
	logic [7:0] pd_val_q  [CHORD_NOTES];
	logic [7:0] pd_vel_q  [CHORD_NOTES];
	logic [CNT_W-1:0] sus_q [CHORD_NOTES];
	logic [CNT_W-1:0] pau_q [CHORD_NOTES];
	logic [CNT_W-1:0] pause_left_q;
	logic [7:0] ty_sus_q [NOTE_TYPES];
	logic [7:0] ty_pau_q [NOTE_TYPES];
	logic [7:0] ty_lvl_q [NOTE_TYPES];
	logic [7:0] d_val_q [CHORD_NOTES];
	logic [7:0] d_vel_q [CHORD_NOTES];
	logic [7:0] d_oval_q [CHORD_NOTES];
	logic [IW-1:0] last_delta_q;

	// control
	ctl_t ctl_q;
	logic [IW-1:0] idx_q;
	logic [2:0] act_q;
	logic [3:0] slot_in_q, ti_in_q;
	logic [7:0] val_in_q, vel_in_q, sp_q, pp_q, lp_q;
	logic [1:0] mode_in_q;
	logic [SW-1:0] add_slot_q;
	logic sus_fin_q;
	logic [7:0] emit_q [3];
	logic [1:0] emit_n_q, emit_i_q;
	logic [7:0] lvl_q;
	logic [CNT_W-1:0] len_q;

	// output register
	logic       ov_q, okind_q, olast_q;
	logic [7:0] obyte_q;
	logic [4:0] oslot_q;
	logic       ofree;

	// shared unit
	logic             mul_start, mul_done;
	logic [CNT_W-1:0] mul_a, mul_q;
	logic [7:0]       mul_b;

	mcs_divmul u_dm (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .q(mul_q));

	assign ofree = !ov_q || out.ready;
	assign in.ready = (ctl_q == CT_IDLE);
	assign cfg.ready = 1'b1;
	assign out.valid = ov_q;
	assign out.kind = okind_q;
	assign out.data_byte = obyte_q;
	assign out.slot_taken = oslot_q;
	assign out.last = olast_q;

	logic idx_end;
	logic [IW-1:0] idx_nx;
	logic [3:0] cur_t;
	logic cur_t_ok;
	logic off_more;
	assign idx_nx = IW'(idx_q + 1'b1);
	assign idx_end = (32'(idx_q) == CHORD_NOTES - 1) || !used_q[idx_nx];
	assign cur_t = ch_type_q[idx_q];
	assign cur_t_ok = (cur_t < 4'(NOTE_TYPES));
	assign off_more = !idx_end;

	// shared-unit operands, chosen by phase
	always_comb begin
		mul_start = 1'b0;
		mul_a = len_q;
		mul_b = '0;
		case (ctl_q)
			CT_ON_MUL1: begin
				mul_start = 1'b1;
				mul_b = cur_t_ok ? ty_sus_q[cur_t] : 8'd0;
			end
			CT_ON_MUL2: begin
				mul_a = CNT_W'(ch_vel_q[idx_q]);
				mul_b = cur_t_ok ? ty_lvl_q[cur_t] : 8'd0;
				mul_start = 1'b1;
			end
			CT_ON_MUL3: begin
				mul_b = cur_t_ok ? ty_pau_q[cur_t] : 8'd0;
				mul_start = 1'b1;
			end
			default: ;
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quarter_q <= QUARTER_RST;
			channel_q <= '0;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_QUARTER: quarter_q <= cfg.data;
				REG_CHANNEL: channel_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// payload arrays without reset
	always_ff @(posedge clk) begin
		if (ctl_q == CT_DISPATCH) begin
			case (action_t'(act_q))
				ACT_ADD: if (32'(add_slot_q) < CHORD_NOTES) begin
					ch_type_q[IW'(add_slot_q)] <= ti_in_q;
					ch_val_q[IW'(add_slot_q)] <= val_in_q;
					ch_vel_q[IW'(add_slot_q)] <= vel_in_q;
				end
				default: ;
			endcase
		end
		if (ctl_q == CT_ON_HDR && ofree && pend_q[idx_q]) begin
			ch_type_q[idx_q] <= pd_type_q[idx_q];
			ch_val_q[idx_q] <= pd_val_q[idx_q];
			ch_vel_q[idx_q] <= pd_vel_q[idx_q];
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CT_IDLE;
			seq_q <= SQ_INIT;
			mode_q <= MODE_IDLE;
			stop_req_q <= 1'b0;
			stopped_q <= 1'b0;
			used_q <= '0;
			pend_q <= '0;
			dnew_q <= '0;
			last_delta_q <= '0;
			pause_left_q <= '0;
			ov_q <= 1'b0;
			idx_q <= '0;
			sus_fin_q <= 1'b0;
			emit_n_q <= '0;
			emit_i_q <= '0;
			for (int i = 0; i < CHORD_NOTES; i++) begin
				sus_q[i] <= '0;
				pau_q[i] <= '0;
				pd_type_q[i] <= '0;
				pd_val_q[i] <= '0;
				pd_vel_q[i] <= '0;
				d_val_q[i] <= '0;
				d_vel_q[i] <= '0;
				d_oval_q[i] <= '0;
			end
			for (int t = 0; t < NOTE_TYPES; t++) begin
				ty_sus_q[t] <= SUS_RST;
				ty_pau_q[t] <= PAU_RST;
				ty_lvl_q[t] <= LVL_RST;
			end
		end else begin
			if (out.ready) ov_q <= 1'b0;
			case (ctl_q)
				CT_IDLE: if (in.valid) begin
					act_q <= in.action;
					slot_in_q <= in.slot;
					ti_in_q <= in.type_index;
					val_in_q <= in.note_value;
					vel_in_q <= in.velocity;
					mode_in_q <= in.mode;
					sp_q <= in.sustain_pct;
					pp_q <= in.pause_pct;
					lp_q <= in.level_pct;
					add_slot_q <= SW'(CHORD_NOTES);
					for (int i = CHORD_NOTES - 1; i >= 0; i--)
						if (!used_q[i]) add_slot_q <= SW'(i);
					ctl_q <= CT_DISPATCH;
				end
				CT_DISPATCH: begin
					ctl_q <= CT_IDLE;
					idx_q <= '0;
					case (action_t'(act_q))
						ACT_ADD: begin
							if (32'(add_slot_q) < CHORD_NOTES) used_q[IW'(add_slot_q)] <= 1'b1;
							ctl_q <= CT_ADD;
						end
						ACT_SET: if (32'(slot_in_q) < CHORD_NOTES) begin
							if (ti_in_q < 4'(NOTE_TYPES)) pd_type_q[IW'(slot_in_q)] <= ti_in_q;
							if (!val_in_q[7]) pd_val_q[IW'(slot_in_q)] <= val_in_q;
							if (!vel_in_q[7]) pd_vel_q[IW'(slot_in_q)] <= vel_in_q;
							pend_q[IW'(slot_in_q)] <= 1'b1;
						end
						ACT_DELTA: if (32'(slot_in_q) < CHORD_NOTES) begin
							d_oval_q[IW'(slot_in_q)] <= d_val_q[IW'(slot_in_q)];
							d_val_q[IW'(slot_in_q)] <= val_in_q;
							d_vel_q[IW'(slot_in_q)] <= vel_in_q;
							dnew_q[IW'(slot_in_q)] <= 1'b1;
							last_delta_q <= IW'(slot_in_q);
						end
						ACT_MODE: mode_q <= op_mode_t'(mode_in_q);
						ACT_STOP: stop_req_q <= 1'b1;
						ACT_RESUME: begin
							stop_req_q <= 1'b0;
							stopped_q <= 1'b0;
						end
						ACT_TYPE: if (ti_in_q < 4'(NOTE_TYPES)) begin
							ty_sus_q[ti_in_q] <= sp_q;
							ty_pau_q[ti_in_q] <= pp_q;
							ty_lvl_q[ti_in_q] <= lp_q;
						end
						default: begin
							// tick
							case (seq_q)
								SQ_INIT: seq_q <= SQ_IDLE;
								SQ_IDLE: begin
									if (mode_q == MODE_SEQ) seq_q <= SQ_ON;
									else if (mode_q == MODE_DELTA) seq_q <= SQ_WAIT;
								end
								SQ_ON: begin
									if (stop_req_q || stopped_q) stopped_q <= 1'b1;
									else if (!used_q[0]) seq_q <= SQ_IDLE;
									else begin
										emit_q[0] <= STATUS_ON | {4'd0, channel_q};
										emit_n_q <= 2'd1;
										emit_i_q <= '0;
										ctl_q <= CT_EMIT;
										seq_q <= SQ_SUS;
									end
								end
								SQ_SUS: begin
									if (used_q[0]) begin
										sus_fin_q <= 1'b0;
										ctl_q <= CT_SUS;
									end
								end
								SQ_OFF: begin
									seq_q <= SQ_PAUSE;
									if (used_q[0]) begin
										pause_left_q <= pau_q[0];
										emit_q[0] <= STATUS_OFF | {4'd0, channel_q};
										emit_n_q <= 2'd1;
										emit_i_q <= '0;
										ctl_q <= CT_EMIT;
									end
								end
								SQ_PAUSE: begin
									if (pause_left_q != '0) pause_left_q <= pause_left_q - 1'b1;
									else seq_q <= (mode_q == MODE_SEQ) ? SQ_ON : SQ_IDLE;
								end
								SQ_WAIT: if (mode_q != MODE_DELTA || dnew_q[last_delta_q])
									seq_q <= SQ_REL;
								SQ_REL: begin
									seq_q <= (mode_q == MODE_DELTA) ? SQ_NEW : SQ_IDLE;
									if (d_oval_q[last_delta_q] != 8'd0) begin
										emit_q[0] <= STATUS_OFF | {4'd0, channel_q};
										emit_q[1] <= d_oval_q[last_delta_q];
										emit_q[2] <= OFF_VELOCITY;
										emit_n_q <= 2'd3;
										emit_i_q <= '0;
										ctl_q <= CT_EMIT;
									end
								end
								SQ_NEW: begin
									emit_q[0] <= STATUS_ON | {4'd0, channel_q};
									emit_q[1] <= d_val_q[last_delta_q];
									emit_q[2] <= d_vel_q[last_delta_q];
									emit_n_q <= 2'd3;
									emit_i_q <= '0;
									ctl_q <= CT_EMIT;
									dnew_q[last_delta_q] <= 1'b0;
									seq_q <= SQ_WAIT;
								end
								default: seq_q <= SQ_IDLE;
							endcase
						end
					endcase
				end
				CT_ADD: if (ofree) begin
					ov_q <= 1'b1;
					okind_q <= 1'b1;
					obyte_q <= '0;
					oslot_q <= 5'(add_slot_q);
					olast_q <= 1'b1;
					ctl_q <= CT_IDLE;
				end
				// plain byte list: header status, or delta triples
				CT_EMIT: if (ofree) begin
					ov_q <= 1'b1;
					okind_q <= 1'b0;
					obyte_q <= emit_q[emit_i_q];
					oslot_q <= '0;
					olast_q <= 1'b0;
					emit_i_q <= emit_i_q + 1'b1;
					if (emit_i_q + 1'b1 == emit_n_q) begin
						if (seq_q == SQ_SUS) ctl_q <= CT_ON_HDR;
						else if (seq_q == SQ_PAUSE) ctl_q <= CT_OFF_VAL;
						else begin
							olast_q <= 1'b1;
							ctl_q <= CT_IDLE;
						end
					end
				end
				// note on: latch pending, then compute counts and level
				CT_ON_HDR: if (ofree) begin
					pend_q[idx_q] <= 1'b0;
					ctl_q <= CT_ON_VAL;
				end
				CT_ON_VAL: if (ofree) begin
					ov_q <= 1'b1;
					okind_q <= 1'b0;
					obyte_q <= ch_val_q[idx_q];
					oslot_q <= '0;
					olast_q <= 1'b0;
					len_q <= type_length(cur_t, quarter_q);
					emit_i_q <= '0;
					ctl_q <= CT_ON_MUL1;
				end
				CT_ON_MUL1: ctl_q <= CT_ON_MUL2;
				CT_ON_MUL2: ctl_q <= CT_ON_MUL3;
				CT_ON_MUL3: ctl_q <= CT_ON_LVL;
				CT_ON_LVL: begin
					if (mul_done) begin
						case (emit_i_q)
							2'd0: sus_q[idx_q] <= mul_q;
							2'd1: lvl_q <= (mul_q > CNT_W'(LEVEL_MAX)) ? LEVEL_MAX : mul_q[7:0];
							default: pau_q[idx_q] <= mul_q;
						endcase
						emit_i_q <= emit_i_q + 1'b1;
					end
					if (emit_i_q == 2'd3 && ofree) begin
						ov_q <= 1'b1;
						okind_q <= 1'b0;
						obyte_q <= lvl_q;
						oslot_q <= '0;
						emit_i_q <= '0;
						olast_q <= idx_end;
						if (idx_end) ctl_q <= CT_IDLE;
						else begin
							idx_q <= idx_nx;
							ctl_q <= CT_ON_HDR;
						end
					end
				end
				// sustain: count down one chord entry per cycle
				CT_SUS: begin
					if (sus_q[idx_q] != '0) sus_q[idx_q] <= sus_q[idx_q] - 1'b1;
					if (idx_end) begin
						if (sus_fin_q || sus_q[idx_q] == '0) seq_q <= SQ_OFF;
						ctl_q <= CT_IDLE;
					end else begin
						if (sus_q[idx_q] == '0) sus_fin_q <= 1'b1;
						idx_q <= idx_nx;
					end
				end
				CT_OFF_HDR: ctl_q <= CT_OFF_VAL;
				CT_OFF_VAL: if (ofree) begin
					ov_q <= 1'b1;
					okind_q <= 1'b0;
					obyte_q <= ch_val_q[idx_q];
					oslot_q <= '0;
					olast_q <= 1'b0;
					ctl_q <= CT_OFF_VEL;
				end
				CT_OFF_VEL: if (ofree) begin
					ov_q <= 1'b1;
					obyte_q <= OFF_VELOCITY;
					olast_q <= !off_more;
					if (off_more) begin
						idx_q <= idx_nx;
						ctl_q <= CT_OFF_VAL;
					end else ctl_q <= CT_IDLE;
				end
				default: ctl_q <= CT_IDLE;
			endcase
		end
	end

	// an item in work never shows ready
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_q != CT_IDLE) |-> !in.ready) else $error("ready while busy");
	// a finished item leaves no pending unit result
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (ctl_q == CT_ON_LVL)) else $error("stray unit result");
	// acknowledgement carries no MIDI byte
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && okind_q) |-> (obyte_q == 8'd0 && olast_q)) else $error("bad ack");
endmodule
